// File: src/errtp_pkg.sv
package errtp_pkg;

  localparam int CoordW  = 24;
  localparam int SizeW   = 23;
  localparam int BaseW   = 25;
  localparam int WideW   = 27;
  localparam int KappaW  = 16;
  localparam int ProdW   = SizeW + KappaW;
  localparam int StepW   = 4;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  // Kappa 0.552284 in Q0.16, rounded up.
  localparam logic [KappaW-1:0] KappaQ    = 16'd36195;
  localparam logic [ProdW-1:0]  KappaHalf = ProdW'(1) << (KappaW - 1);

  localparam logic signed [WideW-1:0] CoordMax = WideW'(24'sh7FFFFF);
  localparam logic signed [WideW-1:0] CoordMin = -CoordMax - WideW'(1);

  localparam logic [StepW-1:0] LastStepEllipse = 4'd5;
  localparam logic [StepW-1:0] LastStepRect    = 4'd4;
  localparam logic [StepW-1:0] LastStepRound   = 4'd9;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CUBIC = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SHAPE_ELLIPSE = 2'd0,
    SHAPE_RECT    = 2'd1,
    SHAPE_ROUND   = 2'd2
  } shape_t;

  typedef logic signed [WideW-1:0] wide_t;

  typedef struct packed {
    logic                     mode;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
    logic [SizeW-1:0]         radius_x;
    logic [SizeW-1:0]         radius_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [CoordW-1:0] ctrl1_x;
    logic signed [CoordW-1:0] ctrl1_y;
    logic signed [CoordW-1:0] ctrl2_x;
    logic signed [CoordW-1:0] ctrl2_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic                     last;
  } out_item_t;

  // Classified shape as it waits between the front end and the sequencer.
  // For ellipses base is the centre and off the kappa offset; for
  // rectangles base is the near corner, far the opposite corner, and off
  // the radius minus half the radius.
  typedef struct packed {
    shape_t                  shape;
    logic signed [BaseW-1:0] base_x;
    logic signed [BaseW-1:0] base_y;
    logic signed [BaseW-1:0] far_x;
    logic signed [BaseW-1:0] far_y;
    logic [SizeW-1:0]        rad_x;
    logic [SizeW-1:0]        rad_y;
    logic [SizeW-1:0]        off_x;
    logic [SizeW-1:0]        off_y;
  } desc_t;

  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } fifo_stat_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input wide_t v);
    logic signed [CoordW-1:0] r;
    if (v > CoordMax) begin
      r = CoordMax[CoordW-1:0];
    end else if (v < CoordMin) begin
      r = CoordMin[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/errtp_front.sv
module errtp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  errtp_pkg::in_item_t in_item,
  output logic                push,
  output errtp_pkg::desc_t    push_desc
);

  logic                                   s1_valid_r;
  errtp_pkg::shape_t                      s1_shape_r, s1_shape_nxt;
  logic signed [errtp_pkg::BaseW-1:0]     s1_base_x_r, s1_base_x_nxt;
  logic signed [errtp_pkg::BaseW-1:0]     s1_base_y_r, s1_base_y_nxt;
  logic [errtp_pkg::SizeW-1:0]            s1_w_r, s1_w_nxt;
  logic [errtp_pkg::SizeW-1:0]            s1_h_r, s1_h_nxt;
  logic [errtp_pkg::SizeW-1:0]            s1_rx_r, s1_rx_nxt;
  logic [errtp_pkg::SizeW-1:0]            s1_ry_r, s1_ry_nxt;

  logic [errtp_pkg::SizeW-1:0] half_w, half_h, rx_c, ry_c;
  logic                        rx_full, ry_full, both_zero;
  logic [errtp_pkg::ProdW-1:0] prod_x, prod_y;
  logic [errtp_pkg::ProdW-1:0] kap_x, kap_y;

  // Classification: clamp the radii to the half sizes (not in ellipse mode) and pick the shape.
  always_comb begin
    half_w    = in_item.width >> 1;
    half_h    = in_item.height >> 1;
    rx_full   = in_item.radius_x >= half_w;
    ry_full   = in_item.radius_y >= half_h;
    rx_c      = rx_full ? half_w : in_item.radius_x;
    ry_c      = ry_full ? half_h : in_item.radius_y;
    both_zero = (rx_c == '0) && (ry_c == '0);

    s1_base_x_nxt = errtp_pkg::BaseW'(in_item.pos_x);
    s1_base_y_nxt = errtp_pkg::BaseW'(in_item.pos_y);
    s1_w_nxt      = in_item.width;
    s1_h_nxt      = in_item.height;
    s1_rx_nxt     = rx_c;
    s1_ry_nxt     = ry_c;

    if (in_item.mode) begin
      s1_shape_nxt = errtp_pkg::SHAPE_ELLIPSE;
      s1_rx_nxt    = in_item.radius_x;
      s1_ry_nxt    = in_item.radius_y;
    end else if (both_zero) begin
      s1_shape_nxt = errtp_pkg::SHAPE_RECT;
    end else if (rx_full && ry_full) begin
      s1_shape_nxt  = errtp_pkg::SHAPE_ELLIPSE;
      s1_base_x_nxt = errtp_pkg::BaseW'(in_item.pos_x) +
                      $signed({2'b00, half_w});
      s1_base_y_nxt = errtp_pkg::BaseW'(in_item.pos_y) +
                      $signed({2'b00, half_h});
    end else begin
      s1_shape_nxt = errtp_pkg::SHAPE_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_shape_r  <= s1_shape_nxt;
      s1_base_x_r <= s1_base_x_nxt;
      s1_base_y_r <= s1_base_y_nxt;
      s1_w_r      <= s1_w_nxt;
      s1_h_r      <= s1_h_nxt;
      s1_rx_r     <= s1_rx_nxt;
      s1_ry_r     <= s1_ry_nxt;
    end
  end

  // Second step: kappa products and the far corner, written straight
  // into the queue.
  always_comb begin
    prod_x = errtp_pkg::ProdW'(s1_rx_r) * errtp_pkg::ProdW'(errtp_pkg::KappaQ);
    prod_y = errtp_pkg::ProdW'(s1_ry_r) * errtp_pkg::ProdW'(errtp_pkg::KappaQ);
    kap_x  = (prod_x + errtp_pkg::KappaHalf) >> errtp_pkg::KappaW;
    kap_y  = (prod_y + errtp_pkg::KappaHalf) >> errtp_pkg::KappaW;

    push_desc.shape  = s1_shape_r;
    push_desc.base_x = s1_base_x_r;
    push_desc.base_y = s1_base_y_r;
    push_desc.far_x  = s1_base_x_r + $signed({2'b00, s1_w_r});
    push_desc.far_y  = s1_base_y_r + $signed({2'b00, s1_h_r});
    push_desc.rad_x  = s1_rx_r;
    push_desc.rad_y  = s1_ry_r;
    if (s1_shape_r == errtp_pkg::SHAPE_ELLIPSE) begin
      push_desc.off_x = kap_x[errtp_pkg::SizeW-1:0];
      push_desc.off_y = kap_y[errtp_pkg::SizeW-1:0];
    end else begin
      push_desc.off_x = s1_rx_r - (s1_rx_r >> 1);
      push_desc.off_y = s1_ry_r - (s1_ry_r >> 1);
    end
    push = s1_valid_r;
  end

  // Two zero radii never reach the rounded sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_shape_r == errtp_pkg::SHAPE_ROUND) |->
      (s1_rx_r != '0 || s1_ry_r != '0))
    else $error("rounded shape with two zero radii");

endmodule

// File: src/errtp_fifo.sv
module errtp_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  errtp_pkg::desc_t      push_desc,
  input  logic                  pop,
  output errtp_pkg::desc_t      head_desc,
  output errtp_pkg::fifo_stat_t stat
);

  errtp_pkg::desc_t                q_mem_r [errtp_pkg::QDepth];
  logic [errtp_pkg::QPtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [errtp_pkg::QCntW-1:0]     count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head_desc  = q_mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == errtp_pkg::QCntW'(errtp_pkg::QDepth)))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && count_r == '0))
    else $error("queue underflow");

endmodule

// File: src/errtp_back.sv
module errtp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  errtp_pkg::desc_t      head_desc,
  input  errtp_pkg::fifo_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  output errtp_pkg::out_item_t  out_item
);

  logic [errtp_pkg::StepW-1:0] step_r, step_nxt, last_step;
  logic                        out_valid_r;
  errtp_pkg::out_item_t        out_item_r;

  errtp_pkg::wide_t x0, y0, x1, y1, rx, ry, ox, oy;
  errtp_pkg::wide_t c1x, c1y, c2x, c2y, ex, ey;
  errtp_pkg::cmd_t  cmd;
  logic             emit, is_last;

  always_comb begin
    x0 = errtp_pkg::wide_t'(head_desc.base_x);
    y0 = errtp_pkg::wide_t'(head_desc.base_y);
    x1 = errtp_pkg::wide_t'(head_desc.far_x);
    y1 = errtp_pkg::wide_t'(head_desc.far_y);
    rx = errtp_pkg::wide_t'({4'b0000, head_desc.rad_x});
    ry = errtp_pkg::wide_t'({4'b0000, head_desc.rad_y});
    ox = errtp_pkg::wide_t'({4'b0000, head_desc.off_x});
    oy = errtp_pkg::wide_t'({4'b0000, head_desc.off_y});

    cmd = errtp_pkg::CMD_CLOSE;
    c1x = '0; c1y = '0; c2x = '0; c2y = '0; ex = '0; ey = '0;

    case (head_desc.shape)
      errtp_pkg::SHAPE_ELLIPSE: begin
        last_step = errtp_pkg::LastStepEllipse;
        case (step_r)
          4'd0: begin
            cmd = errtp_pkg::CMD_MOVE;
            ex = x0; ey = y0 - ry;
          end
          4'd1: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0 + ox; c1y = y0 - ry;
            c2x = x0 + rx; c2y = y0 - oy;
            ex  = x0 + rx; ey  = y0;
          end
          4'd2: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0 + rx; c1y = y0 + oy;
            c2x = x0 + ox; c2y = y0 + ry;
            ex  = x0;      ey  = y0 + ry;
          end
          4'd3: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0 - ox; c1y = y0 + ry;
            c2x = x0 - rx; c2y = y0 + oy;
            ex  = x0 - rx; ey  = y0;
          end
          4'd4: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0 - rx; c1y = y0 - oy;
            c2x = x0 - ox; c2y = y0 - ry;
            ex  = x0;      ey  = y0 - ry;
          end
          default: cmd = errtp_pkg::CMD_CLOSE;
        endcase
      end
      errtp_pkg::SHAPE_RECT: begin
        last_step = errtp_pkg::LastStepRect;
        case (step_r)
          4'd0: begin
            cmd = errtp_pkg::CMD_MOVE; ex = x0; ey = y0;
          end
          4'd1: begin
            cmd = errtp_pkg::CMD_LINE; ex = x1; ey = y0;
          end
          4'd2: begin
            cmd = errtp_pkg::CMD_LINE; ex = x1; ey = y1;
          end
          4'd3: begin
            cmd = errtp_pkg::CMD_LINE; ex = x0; ey = y1;
          end
          default: cmd = errtp_pkg::CMD_CLOSE;
        endcase
      end
      default: begin
        last_step = errtp_pkg::LastStepRound;
        case (step_r)
          4'd0: begin
            cmd = errtp_pkg::CMD_MOVE; ex = x0 + rx; ey = y0;
          end
          4'd1: begin
            cmd = errtp_pkg::CMD_LINE; ex = x1 - rx; ey = y0;
          end
          4'd2: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x1 - ox; c1y = y0;
            c2x = x1;      c2y = y0 + oy;
            ex  = x1;      ey  = y0 + ry;
          end
          4'd3: begin
            cmd = errtp_pkg::CMD_LINE; ex = x1; ey = y1 - ry;
          end
          4'd4: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x1;      c1y = y1 - oy;
            c2x = x1 - ox; c2y = y1;
            ex  = x1 - rx; ey  = y1;
          end
          4'd5: begin
            cmd = errtp_pkg::CMD_LINE; ex = x0 + rx; ey = y1;
          end
          4'd6: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0 + ox; c1y = y1;
            c2x = x0;      c2y = y1 - oy;
            ex  = x0;      ey  = y1 - ry;
          end
          4'd7: begin
            cmd = errtp_pkg::CMD_LINE; ex = x0; ey = y0 + ry;
          end
          4'd8: begin
            cmd = errtp_pkg::CMD_CUBIC;
            c1x = x0;      c1y = y0 + oy;
            c2x = x0 + ox; c2y = y0;
            ex  = x0 + rx; ey  = y0;
          end
          default: cmd = errtp_pkg::CMD_CLOSE;
        endcase
      end
    endcase

    emit     = !stat.empty;
    is_last  = (step_r == last_step);
    pop      = emit && is_last;
    step_nxt = step_r;
    if (emit) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.command <= cmd;
      out_item_r.ctrl1_x <= errtp_pkg::sat_coord(c1x);
      out_item_r.ctrl1_y <= errtp_pkg::sat_coord(c1y);
      out_item_r.ctrl2_x <= errtp_pkg::sat_coord(c2x);
      out_item_r.ctrl2_y <= errtp_pkg::sat_coord(c2y);
      out_item_r.end_x   <= errtp_pkg::sat_coord(ex);
      out_item_r.end_y   <= errtp_pkg::sat_coord(ey);
      out_item_r.last    <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The shape-ending flag and the close command always travel together.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.last == (out_item_r.command == errtp_pkg::CMD_CLOSE)))
    else $error("last flag does not match close command");

  // A step counter at rest means the next emitted command opens a shape.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && step_r == '0) |=> (out_item_r.command == errtp_pkg::CMD_MOVE))
    else $error("shape did not open with a move");

endmodule

// File: src/ellipse_rounded_rect_to_path_core.sv
// A request that is accepted passes the front-end register and the queue;
// its first command leaves the output register once the sequencer reaches
// it, later ones follow one per cycle. A request yields 5 (plain rectangle),
// 6 (ellipse) or 10 (rounded rectangle) path commands from the sequencer.
// Reset (rst_n low, synchronous) empties the queue and clears all strobes;
// results cannot be held off by the receiver.
module ellipse_rounded_rect_to_path_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  errtp_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output errtp_pkg::out_item_t out_item
);

  // A transaction is taken whenever start is high while busy is low. The
  // front end clamps the corner radii, decides which of the three outlines
  // to draw and forms the centre, far corner and control offsets (one
  // multiplier per axis for the kappa products). The result is a compact
  // descriptor that waits in a four-entry queue until the sequencer picks
  // it up.
  logic                  accept;
  logic                  push;
  logic                  pop;
  errtp_pkg::desc_t      push_desc;
  errtp_pkg::desc_t      head_desc;
  errtp_pkg::fifo_stat_t stat;
  logic                  s1_busy_r;
  logic [errtp_pkg::QCntW:0] occupancy;

  // busy counts both the entries already queued and a descriptor still in
  // the front-end register, so the queue can never be overrun even though
  // the sequencer drains it independently.
  assign occupancy = {1'b0, stat.count} + (errtp_pkg::QCntW + 1)'(s1_busy_r);
  assign busy      = occupancy >= (errtp_pkg::QCntW + 1)'(errtp_pkg::QDepth);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_busy_r <= 1'b0;
    end else begin
      s1_busy_r <= accept;
    end
  end

  errtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .push      (push),
    .push_desc (push_desc)
  );

  errtp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .stat      (stat)
  );

  // The sequencer walks the head descriptor one command per cycle,
  // forming each coordinate as a base value or a two-term sum that is saturated to the
  // signed 24-bit range before it lands in the output register.
  errtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // The front-end register tracks the pushes into the queue exactly.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> push)
    else $error("accepted transaction was not queued");

endmodule
